### src/wcc_pkg.sv
package wcc_pkg;

    localparam int KERNEL_MAX    = 5;
    localparam int COEF_N        = KERNEL_MAX * KERNEL_MAX;
    localparam int STRIDE_MAX    = 8192;
    localparam int HISTORY_DEPTH = 40960;
    localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
    localparam int APB_AW        = 5;
    localparam int DIVIDEND_W    = 28;
    localparam int DIVISOR_W     = 20;

    typedef enum logic [1:0] {
        OP_COEF  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_KERNEL_SIZE = 3'd0,
        REG_IMAGE_WIDTH = 3'd1,
        REG_CHANNELS    = 3'd2,
        REG_FRAME_BYTES = 3'd3,
        REG_DIVIDE_MODE = 3'd4,
        REG_DIVISOR     = 3'd5
    } reg_idx_t;

    localparam logic [1:0] MODE_DIVISOR = 2'd1;
    localparam logic [1:0] MODE_COEFSUM = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ADDR,
        ST_MAC,
        ST_NORM,
        ST_DIV_WAIT,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic [2:0]  kernel_size;
        logic [11:0] image_width;
        logic [2:0]  channels;
        logic [24:0] frame_bytes;
        logic [1:0]  divide_mode;
        logic [15:0] divisor;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic dividing;
        logic result;
    } stat_t;

endpackage

### src/wcc_in_if.sv
interface wcc_in_if;
    import wcc_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic [7:0]         sample;

    modport source (output valid, op, coeff_index, coeff_value, sample, input ready);
    modport sink (input valid, op, coeff_index, coeff_value, sample, output ready);
endinterface

### src/wcc_out_if.sv
interface wcc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic       frame_end;

    modport source (output valid, pixel, frame_end, input ready);
    modport sink (input valid, pixel, frame_end, output ready);
endinterface

### src/wcc_regs.sv
module wcc_regs
    import wcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kernel_size <= 3'd3;
            cfg_reg.image_width <= 12'd640;
            cfg_reg.channels    <= 3'd1;
            cfg_reg.frame_bytes <= 25'd307200;
            cfg_reg.divide_mode <= 2'd0;
            cfg_reg.divisor     <= 16'd1;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_KERNEL_SIZE: cfg_reg.kernel_size <= pwdata[2:0];
                REG_IMAGE_WIDTH: cfg_reg.image_width <= pwdata[11:0];
                REG_CHANNELS:    cfg_reg.channels    <= pwdata[2:0];
                REG_FRAME_BYTES: cfg_reg.frame_bytes <= pwdata[24:0];
                REG_DIVIDE_MODE: cfg_reg.divide_mode <= pwdata[1:0];
                REG_DIVISOR:     cfg_reg.divisor     <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_KERNEL_SIZE: prdata = {29'd0, cfg_reg.kernel_size};
            REG_IMAGE_WIDTH: prdata = {20'd0, cfg_reg.image_width};
            REG_CHANNELS:    prdata = {29'd0, cfg_reg.channels};
            REG_FRAME_BYTES: prdata = {7'd0, cfg_reg.frame_bytes};
            REG_DIVIDE_MODE: prdata = {30'd0, cfg_reg.divide_mode};
            REG_DIVISOR:     prdata = {16'd0, cfg_reg.divisor};
            default:         prdata = 32'd0;
        endcase
    end

endmodule

### src/wcc_div.sv
module wcc_div
    import wcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic [DIVISOR_W-1:0]  d_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W+1:0]  diff;

    assign rem_shift = {rem_reg[DIVISOR_W-1:0], q_reg[DIVIDEND_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b0, d_reg};
    assign quotient  = q_reg;
    assign done      = busy_reg && (cnt_reg == CW'(DIVIDEND_W));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            d_reg   <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg && !done)
        begin
            if (!diff[DIVISOR_W+1])
            begin
                rem_reg <= diff[DIVISOR_W:0];
                q_reg   <= {q_reg[DIVIDEND_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                q_reg   <= {q_reg[DIVIDEND_W-2:0], 1'b0};
            end
        end
    end

endmodule

### src/wcc_engine.sv
module wcc_engine
    import wcc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    wcc_in_if.sink      in_ch,
    wcc_out_if.source   out_ch,
    output stat_t       stat
);

    state_t state_reg, state_next;

    logic signed [15:0] coef_tbl [COEF_N];
    logic [7:0]         hist_mem [HISTORY_DEPTH];

    logic [24:0]        br_reg, rs_reg;
    logic [HIST_AW-1:0] wr_slot_reg, y_slot_reg;
    logic signed [17:0] row_off_reg, off_reg;
    logic [2:0]         col_reg;
    logic [4:0]         ti_reg;
    logic               last_reg, inr_reg;
    logic signed [15:0] coef_reg;
    logic [7:0]         rd_data_reg;
    logic signed [28:0] acc_reg;
    logic signed [20:0] csum_reg;
    logic [DIVIDEND_W-1:0] q_reg;
    logic               neg_reg;
    logic               out_valid_reg;
    logic [7:0]         out_pixel_reg;
    logic               out_end_reg;

    logic [2:0]  k;
    logic [1:0]  p, sm;
    logic [4:0]  kk;
    logic [14:0] stride_full;
    logic [13:0] stride;
    logic [14:0] step_sum;
    logic [16:0] ahead;
    logic [14:0] rowbase0;
    logic [3:0]  colbase;

    logic        accept, byte_wr, emit_ok, out_free, load_out, frame_end;
    logic signed [26:0] n;
    logic        inr;
    logic signed [17:0] slot_raw;
    logic [HIST_AW-1:0] rd_addr;
    logic signed [24:0] prod;
    logic signed [17:0] row_next;
    logic [DIVIDEND_W-1:0] acc_mag;
    logic [DIVISOR_W-1:0]  dmag;
    logic        dsign, use_div, div_start, div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [7:0]  pixel;

    assign k  = (cfg.kernel_size > 3'(KERNEL_MAX)) ? 3'(KERNEL_MAX) : cfg.kernel_size;
    assign p  = k[2:1];
    assign sm = (k == 3'd0) ? 2'd0 : 2'((k - 3'd1) >> 1);
    assign kk = 5'({2'b0, k} * {2'b0, k});

    assign stride_full = {3'b0, cfg.image_width} * {12'b0, cfg.channels};
    assign stride = (stride_full > 15'(STRIDE_MAX)) ? 14'(STRIDE_MAX) : stride_full[13:0];
    assign step_sum = {1'b0, stride} + {12'b0, cfg.channels};

    always_comb
    begin
        case (p)
            2'd1:    ahead = {2'b0, step_sum};
            2'd2:    ahead = {1'b0, step_sum, 1'b0};
            default: ahead = '0;
        endcase
        case (sm)
            2'd1:
            begin
                rowbase0 = {1'b0, stride};
                colbase  = {1'b0, cfg.channels};
            end
            2'd2:
            begin
                rowbase0 = {stride, 1'b0};
                colbase  = {cfg.channels, 1'b0};
            end
            default:
            begin
                rowbase0 = '0;
                colbase  = '0;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept  = in_ch.valid && in_ch.ready;
    assign byte_wr = accept && (in_ch.op == OP_BYTE) && (br_reg < cfg.frame_bytes);

    assign emit_ok = (rs_reg < br_reg) &&
                     ((br_reg >= cfg.frame_bytes) || ({1'b0, br_reg} > ({1'b0, rs_reg} + 26'(ahead))));

    // tap address
    assign n   = $signed({2'b0, rs_reg}) + {{9{off_reg[17]}}, off_reg};
    assign inr = !n[26] && (n[25:0] < {1'b0, cfg.frame_bytes});
    assign slot_raw = $signed({2'b0, y_slot_reg}) + off_reg;
    always_comb
    begin
        if (slot_raw[17])
            rd_addr = HIST_AW'(slot_raw + 18'(HISTORY_DEPTH));
        else if (slot_raw >= 18'(HISTORY_DEPTH))
            rd_addr = HIST_AW'(slot_raw - 18'(HISTORY_DEPTH));
        else
            rd_addr = HIST_AW'(slot_raw);
    end

    assign prod     = coef_reg * $signed({1'b0, rd_data_reg});
    assign row_next = row_off_reg + $signed({4'b0, stride});

    // normalization
    assign acc_mag = acc_reg[28] ? DIVIDEND_W'(-acc_reg) : acc_reg[DIVIDEND_W-1:0];
    always_comb
    begin
        dsign   = 1'b0;
        dmag    = DIVISOR_W'(1);
        use_div = 1'b0;
        case (cfg.divide_mode)
            MODE_DIVISOR:
            begin
                use_div = 1'b1;
                if (cfg.divisor != 16'd0)
                    dmag = {4'b0, cfg.divisor};
            end
            MODE_COEFSUM:
            begin
                use_div = 1'b1;
                if (csum_reg != 21'sd0)
                begin
                    dsign = csum_reg[20];
                    dmag  = csum_reg[20] ? DIVISOR_W'(-csum_reg) : csum_reg[DIVISOR_W-1:0];
                end
            end
            default: ;
        endcase
    end
    assign div_start = (state_reg == ST_NORM) && use_div;

    wcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_mag),
        .divisor  (dmag),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        if (neg_reg || (q_reg == '0))
            pixel = 8'd0;
        else if (q_reg > DIVIDEND_W'(255))
            pixel = 8'd255;
        else
            pixel = q_reg[7:0];
    end

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign load_out  = (state_reg == ST_RESULT) && out_free;
    assign frame_end = ({1'b0, rs_reg} + 26'd1) >= {1'b0, cfg.frame_bytes};

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel     = out_pixel_reg;
    assign out_ch.frame_end = out_end_reg;

    assign stat.busy     = (state_reg != ST_IDLE);
    assign stat.dividing = (state_reg == ST_DIV_WAIT);
    assign stat.result   = (state_reg == ST_RESULT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((in_ch.op == OP_BYTE) || (in_ch.op == OP_FLUSH)))
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (!emit_ok)
                    state_next = ST_IDLE;
                else if (k == 3'd0)
                    state_next = ST_NORM;
                else
                    state_next = ST_ADDR;
            end
            ST_ADDR:     state_next = ST_MAC;
            ST_MAC:      state_next = last_reg ? ST_NORM : ST_ADDR;
            ST_NORM:     state_next = use_div ? ST_DIV_WAIT : ST_RESULT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // frame counters and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            br_reg        <= '0;
            rs_reg        <= '0;
            wr_slot_reg   <= '0;
            y_slot_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_wr)
            begin
                br_reg      <= br_reg + 25'd1;
                wr_slot_reg <= (wr_slot_reg == HIST_AW'(HISTORY_DEPTH - 1)) ? '0
                                                                           : wr_slot_reg + 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                if (frame_end)
                begin
                    br_reg      <= '0;
                    rs_reg      <= '0;
                    wr_slot_reg <= '0;
                    y_slot_reg  <= '0;
                end
                else
                begin
                    rs_reg     <= rs_reg + 25'd1;
                    y_slot_reg <= (y_slot_reg == HIST_AW'(HISTORY_DEPTH - 1)) ? '0
                                                                             : y_slot_reg + 1'b1;
                end
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept && (in_ch.op == OP_COEF) && (in_ch.coeff_index < 5'(COEF_N)))
            coef_tbl[in_ch.coeff_index] <= in_ch.coeff_value;

        if (byte_wr)
            hist_mem[wr_slot_reg] <= in_ch.sample;
        if (state_reg == ST_ADDR)
            rd_data_reg <= hist_mem[rd_addr];

        case (state_reg)
            ST_CHECK:
            begin
                acc_reg     <= '0;
                csum_reg    <= '0;
                col_reg     <= '0;
                ti_reg      <= '0;
                row_off_reg <= -$signed({3'b0, rowbase0});
                off_reg     <= -$signed({3'b0, rowbase0}) - $signed({14'b0, colbase});
            end
            ST_ADDR:
            begin
                inr_reg  <= inr;
                coef_reg <= coef_tbl[ti_reg];
                csum_reg <= csum_reg + {{5{coef_tbl[ti_reg][15]}}, coef_tbl[ti_reg]};
                last_reg <= (ti_reg == kk - 5'd1);
                ti_reg   <= ti_reg + 5'd1;
                if (col_reg == k - 3'd1)
                begin
                    col_reg     <= '0;
                    row_off_reg <= row_next;
                    off_reg     <= row_next - $signed({14'b0, colbase});
                end
                else
                begin
                    col_reg <= col_reg + 3'd1;
                    off_reg <= off_reg + $signed({15'b0, cfg.channels});
                end
            end
            ST_MAC:
            begin
                if (inr_reg)
                    acc_reg <= acc_reg + {{4{prod[24]}}, prod};
            end
            ST_NORM:
            begin
                neg_reg <= acc_reg[28] ^ dsign;
                q_reg   <= acc_mag;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    q_reg <= div_q;
            end
            default: ;
        endcase

        if (load_out)
        begin
            out_pixel_reg <= pixel;
            out_end_reg   <= frame_end;
        end
    end

endmodule

### src/window_convolution_clamp_top.sv
// Streaming k-by-k convolution over one interleaved 8-bit frame.
// in_ch carries coefficient writes, frame bytes and flush items; out_ch
// carries filtered bytes in frame order, frame_end marking the last one.
// Registers are to be written over the APB port only while the block is
// idle; the block itself does not enforce this.
// An item that emits a result is accepted and checked, then runs the tap
// loop (one history read and one multiply-accumulate per tap), then
// normalization and, when dividing, the bit-serial divider, and finally
// loads the output register.
// Results trail the input by the lookahead of the window; flush items
// release the tail of the frame.
// in_ch.ready is high only while the sequencer is idle.
// The output register holds a result until taken; the next input item is
// accepted meanwhile, and a new result waits in the sequencer if the
// register is still full.
// Reset clears the frame counters and loads the register defaults; the
// coefficient table and byte history are undefined until written.
module window_convolution_clamp_top
    import wcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    wcc_in_if.sink            in_ch,
    wcc_out_if.source         out_ch
);

    cfg_t  cfg;
    stat_t stat;

    wcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .stat   (stat)
    );

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !in_ch.ready)
        else $error("input taken while sequencer busy");

    a_valid_from_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(stat.result))
        else $error("output valid without a finished result");

    a_div_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        stat.dividing |=> (stat.dividing || stat.result))
        else $error("divide phase left without result");

endmodule

### tb/sv/window_convolution_clamp_checker.sv
module window_convolution_clamp_checker
    import wcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    wcc_in_if                 in_mon,
    wcc_out_if                out_mon,
    output int                errors,
    output int                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_end;
    } pixel_t;

    logic [2:0]  kernel_size;
    logic [11:0] image_width;
    logic [2:0]  channels;
    logic [24:0] frame_bytes;
    logic [1:0]  divide_mode;
    logic [15:0] divisor;

    logic signed [15:0] coefs [COEF_N];
    logic [7:0]         history [HISTORY_DEPTH];
    longint             received;
    longint             emitted;
    pixel_t             expected_pixels [$];

    assign pending = expected_pixels.size();

    function automatic longint eff_k();
        return (kernel_size > KERNEL_MAX) ? KERNEL_MAX : kernel_size;
    endfunction

    function automatic longint eff_stride();
        longint s;
        s = longint'(image_width) * longint'(channels);
        return (s > STRIDE_MAX) ? STRIDE_MAX : s;
    endfunction

    function automatic logic [7:0] filter_pixel(longint y);
        longint k, p, s, st, ch, acc, dv, n, sum;
        k = eff_k();
        p = k / 2;
        s = p - k + 1;
        st = eff_stride();
        ch = channels;
        acc = 0;
        dv = 1;
        for (longint r = s; r <= p; r++)
            for (longint c = s; c <= p; c++)
            begin
                n = y + r * st + c * ch;
                if (n >= 0 && n < longint'(frame_bytes))
                    acc += longint'(coefs[k * (r - s) + (c - s)]) *
                           longint'(history[n % HISTORY_DEPTH]);
            end
        if (divide_mode == MODE_DIVISOR)
        begin
            dv = (divisor == 0) ? 1 : divisor;
        end
        else if (divide_mode == MODE_COEFSUM)
        begin
            sum = 0;
            for (int i = 0; i < k * k; i++)
                sum += coefs[i];
            dv = (sum == 0) ? 1 : sum;
        end
        acc = acc / dv;
        if (acc > 255)
            acc = 255;
        if (acc < 0)
            acc = 0;
        return acc[7:0];
    endfunction

    function automatic bit result_due();
        longint ahead;
        if (emitted >= received)
            return 0;
        if (received >= longint'(frame_bytes))
            return 1;
        ahead = (eff_k() / 2) * (eff_stride() + longint'(channels));
        return received > emitted + ahead;
    endfunction

    task automatic accept_item(logic [1:0] op, logic [4:0] idx, logic signed [15:0] val,
                               logic [7:0] smp);
        pixel_t e;
        if (op == OP_COEF)
        begin
            if (idx < COEF_N)
                coefs[idx] = val;
            return;
        end
        if (op == OP_NONE)
            return;
        if (op == OP_BYTE && received < longint'(frame_bytes))
        begin
            history[received % HISTORY_DEPTH] = smp;
            received++;
        end
        if (!result_due())
            return;
        e.pixel = filter_pixel(emitted);
        e.frame_end = 1'b0;
        emitted++;
        if (emitted >= longint'(frame_bytes))
        begin
            e.frame_end = 1'b1;
            received = 0;
            emitted = 0;
        end
        expected_pixels.push_back(e);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t e;
        if (!rst_n)
        begin
            kernel_size = 3;
            image_width = 640;
            channels = 1;
            frame_bytes = 307200;
            divide_mode = 0;
            divisor = 1;
            received = 0;
            emitted = 0;
            errors = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr >> 2)
                    REG_KERNEL_SIZE: kernel_size = pwdata[2:0];
                    REG_IMAGE_WIDTH: image_width = pwdata[11:0];
                    REG_CHANNELS:    channels = pwdata[2:0];
                    REG_FRAME_BYTES: frame_bytes = pwdata[24:0];
                    REG_DIVIDE_MODE: divide_mode = pwdata[1:0];
                    REG_DIVISOR:     divisor = pwdata[15:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected transfer: pixel %0d frame_end %0b",
                                 out_mon.pixel, out_mon.frame_end);
                end
                else
                begin
                    e = expected_pixels.pop_front();
                    if (e.pixel !== out_mon.pixel || e.frame_end !== out_mon.frame_end)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected pixel %0d frame_end %0b, got %0d %0b",
                                     e.pixel, e.frame_end, out_mon.pixel, out_mon.frame_end);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                accept_item(in_mon.op, in_mon.coeff_index, in_mon.coeff_value, in_mon.sample);
        end
    end
endmodule

### tb/sv/window_convolution_clamp_top_test.sv
module window_convolution_clamp_top_test;
    import wcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                errors;
    int                pending;

    wcc_in_if  in_ch ();
    wcc_out_if out_ch ();

    window_convolution_clamp_top dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch.sink), .out_ch(out_ch.source)
    );

    window_convolution_clamp_checker chk (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .in_mon(in_ch), .out_mon(out_ch), .errors(errors), .pending(pending)
    );

    int tx_idle;
    int rx_idle;
    int hold_ask;
    int hold_seen;
    int hold_left;
    int n_items;
    int quiet;

    // own copy of settings, used to size the frame and its flush tail
    int cur_k;
    int cur_w;
    int cur_ch;
    int cur_fb;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = 1'b1;
            #10 clk = 1'b0;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_FLUSH;
        in_ch.coeff_index = '0;
        in_ch.coeff_value = '0;
        in_ch.sample = '0;
        out_ch.ready = 1'b0;
        tx_idle = 13;
        rx_idle = 69;
        hold_ask = 0;
        hold_seen = 0;
        hold_left = 0;
        n_items = 0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else if (hold_ask != hold_seen)
        begin
            hold_seen = hold_ask;
            hold_left = 400;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(99) >= rx_idle);
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet = 0;
        else
            quiet++;
        if (quiet >= 5000)
        begin
            $display("** window_convolution_clamp_top: FAILED **");
            $finish;
        end
    end

    // the caller drives valid again at the negedge where this returns
    task automatic push(logic [1:0] op, logic [4:0] idx, logic [15:0] val, logic [7:0] smp);
        while ($urandom_range(99) < tx_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.op <= op;
        in_ch.coeff_index <= idx;
        in_ch.coeff_value <= val;
        in_ch.sample <= smp;
        do
            @(posedge clk);
        while (!in_ch.ready);
        n_items++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'(idx) << 2;
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
    endtask

    task automatic set_frame(int k, int w, int ch, int fb, int mode, int dv);
        reg_write(REG_KERNEL_SIZE, k);
        reg_write(REG_IMAGE_WIDTH, w);
        reg_write(REG_CHANNELS, ch);
        reg_write(REG_FRAME_BYTES, fb);
        reg_write(REG_DIVIDE_MODE, mode);
        reg_write(REG_DIVISOR, dv);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_k = k & 7;
        cur_w = w & 12'hFFF;
        cur_ch = ch & 7;
        cur_fb = fb & 25'h1FFFFFF;
    endtask

    function automatic int tail_flushes();
        longint k, st, ahead, sent;
        k = (cur_k > KERNEL_MAX) ? KERNEL_MAX : cur_k;
        st = longint'(cur_w) * cur_ch;
        if (st > STRIDE_MAX)
            st = STRIDE_MAX;
        ahead = (k / 2) * (st + cur_ch);
        if (cur_fb == 0)
            return 0;
        sent = ((cur_fb - 1 - ahead) > 0 ? (cur_fb - 1 - ahead) : 0) + 1;
        return cur_fb - sent;
    endfunction

    function automatic logic [15:0] rand_coef();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed($urandom_range(40)) - 8);
        endcase
    endfunction

    task automatic run_frame(bit allow_drop);
        int fl;
        for (int i = 0; i < cur_fb; i++)
        begin
            if ($urandom_range(99) < 8)
                push(OP_COEF, 5'($urandom_range(31)), rand_coef(), 8'($urandom));
            if ($urandom_range(99) < 3)
                push(OP_NONE, 5'($urandom), 16'($urandom), 8'($urandom));
            push(OP_BYTE, 5'($urandom), 16'($urandom), 8'($urandom));
        end
        fl = tail_flushes();
        for (int i = 0; i < fl; i++)
        begin
            // a byte past the end of the frame is dropped but still releases a result
            if (allow_drop && i == 0)
                push(OP_BYTE, 5'($urandom), 16'($urandom), 8'($urandom));
            else
                push(OP_FLUSH, 5'($urandom), 16'($urandom), 8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        int k, w, ch, fb, mode, dv, frames;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < COEF_N; i++)
            push(OP_COEF, 5'(i), (i == 0) ? 16'h8000 : (i == 24) ? 16'h7FFF : 16'(i + 1),
                 8'h00);
        push(OP_COEF, 5'd31, 16'h1234, 8'h00);
        drain();
        set_frame(3, 3, 1, 9, 2, 1);
        push(OP_BYTE, 0, 0, 8'h00);
        push(OP_BYTE, 0, 0, 8'hFF);
        push(OP_NONE, 5'h1F, 16'hFFFF, 8'hFF);
        for (int i = 0; i < 7; i++)
            push(OP_BYTE, 0, 0, 8'($urandom));
        for (int i = 0; i < tail_flushes(); i++)
            push(OP_FLUSH, 0, 0, 0);
        drain();
        set_frame(5, 2048, 4, 0, 3, 0);
        push(OP_BYTE, 0, 0, 8'hAA);
        push(OP_FLUSH, 0, 0, 0);
        drain();
        set_frame(7, 4095, 7, 25'h1FFFFFF, 1, 65535);

        frames = 0;
        while (n_items < 1350)
        begin
            if (n_items > 900)
            begin
                tx_idle = 0;
                rx_idle = 0;
            end
            else if (n_items > 450)
            begin
                tx_idle = 69;
                rx_idle = 13;
            end
            if ($urandom_range(99) < 8)
                k = $urandom_range(7);
            else
                k = $urandom_range(5, 1);
            w = ($urandom_range(99) < 5) ? 2048 : $urandom_range(6, 1);
            ch = ($urandom_range(99) < 5) ? $urandom_range(7) : $urandom_range(4, 1);
            fb = (w > 8 ? 6 : w * (ch == 0 ? 1 : ch)) * $urandom_range(4, 1);
            if ($urandom_range(3) == 0)
                fb = $urandom_range(fb + 4, 1);
            mode = $urandom_range(3);
            dv = ($urandom_range(9) == 0) ? $urandom_range(1) * 65535 : $urandom_range(300);
            set_frame(k, w, ch, fb, mode, dv);
            if ($urandom_range(2) == 0)
                for (int i = 0; i < COEF_N; i++)
                    push(OP_COEF, 5'(i), rand_coef(), 8'($urandom));
            if (frames == 4)
                hold_ask++;
            run_frame($urandom_range(3) == 0);
            frames++;
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);
        if (errors == 0)
            $display("** window_convolution_clamp_top: PASSED **");
        else
            $display("** window_convolution_clamp_top: FAILED **");
        $finish;
    end
endmodule
